// ===== rtl/core/rsc_pkg.sv =====
// Shared types, codes and helpers of the RPN stack calculator.
package rsc_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int TOKEN_CHARS_DEF = 48;
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int DIV_N_W = 48;
    localparam int DIV_D_W = 32;

    localparam logic [14:0] INT_LIMIT = 15'd32767;
    localparam logic [2:0]  FRAC_MAX_DIGITS = 3'd5;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_Q_LO  = 8'h71;
    localparam logic [7:0] CH_Q_UP  = 8'h51;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_STACK_FULL = 3'd1,
        ST_TOKEN_FULL = 3'd2,
        ST_IGNORED    = 3'd3,
        ST_DIV_ZERO   = 3'd4,
        ST_SATURATED  = 3'd5,
        ST_QUIT       = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        K_DIGIT = 3'd0,
        K_POINT = 3'd1,
        K_END   = 3'd2,
        K_LINE  = 3'd3,
        K_OP    = 3'd4,
        K_QUIT  = 3'd5,
        K_OTHER = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        kind_t      kind;
        op_t        op;
        logic [3:0] digit;
    } cmd_t;

    typedef struct packed {
        logic halted;
        logic idle;
    } back_status_t;

    function automatic logic [16:0] pow_ten(input logic [2:0] n);
        case (n)
            3'd0:    pow_ten = 17'd1;
            3'd1:    pow_ten = 17'd10;
            3'd2:    pow_ten = 17'd100;
            3'd3:    pow_ten = 17'd1000;
            3'd4:    pow_ten = 17'd10000;
            3'd5:    pow_ten = 17'd100000;
            default: pow_ten = 17'd1;
        endcase
    endfunction

    // {saturated, value} clamped to the int32 range
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat32 = {1'b1, 32'h7FFF_FFFF};
        else if (v < -64'sd2147483648)
            sat32 = {1'b1, 32'h8000_0000};
        else
            sat32 = {1'b0, v[31:0]};
    endfunction

endpackage

// ===== rtl/core/rsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/rsc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module rsc_div #(
    parameter int NW = rsc_pkg::DIV_N_W,
    parameter int DW = rsc_pkg::DIV_D_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);
    localparam int CNW = $clog2(NW + 1);

    logic [DW:0]    rem_reg, rem_next;
    logic [NW-1:0]  quo_reg, quo_next;
    logic [DW-1:0]  dvs_reg, dvs_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [DW:0]    shifted;
    logic           fits;

    assign shifted = {rem_reg[DW-1:0], quo_reg[NW-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_next = {quo_reg[NW-2:0], fits};
            cnt_next = cnt_reg - CNW'(1);
            if (cnt_reg == CNW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvs_reg  <= dvs_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== rtl/core/rsc_cmd_fifo.sv =====
// Short command queue between the classifier and the execution unit.
module rsc_cmd_fifo #(
    parameter int DEPTH = rsc_pkg::CMD_QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  rsc_pkg::cmd_t              wr_cmd,
    input  logic                       rd_en,
    output rsc_pkg::cmd_t              rd_cmd,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] level
);
    import rsc_pkg::*;

    localparam int PW  = $clog2(DEPTH);
    localparam int LVW = $clog2(DEPTH + 1);

    cmd_t           mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [LVW-1:0] level_reg, level_next;
    logic           wr_ok;
    logic           rd_ok;

    assign empty = level_reg == '0;
    assign full  = level_reg == LVW'(DEPTH);
    assign wr_ok = wr_en && !full;
    assign rd_ok = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (wr_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (wr_ok && !rd_ok)
        begin
            level_next = level_reg + LVW'(1);
        end
        else if (rd_ok && !wr_ok)
        begin
            level_next = level_reg - LVW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign rd_cmd = mem_reg[rd_ptr_reg];
    assign level  = level_reg;
endmodule

// ===== rtl/core/rsc_front.sv =====
// Input side: takes characters and sorts them into commands.
module rsc_front (
    input  logic          push,
    input  logic [7:0]    ch,
    input  logic          fifo_full,
    output logic          full,
    output logic          wr_en,
    output rsc_pkg::cmd_t cmd
);
    import rsc_pkg::*;

    assign full  = fifo_full;
    assign wr_en = push && !fifo_full;

    always_comb
    begin
        cmd.kind  = K_OTHER;
        cmd.op    = OP_ADD;
        cmd.digit = ch[3:0];
        case (ch)
            CH_Q_LO, CH_Q_UP: cmd.kind = K_QUIT;
            CH_PLUS:
            begin
                cmd.kind = K_OP;
                cmd.op   = OP_ADD;
            end
            CH_MINUS:
            begin
                cmd.kind = K_OP;
                cmd.op   = OP_SUB;
            end
            CH_STAR:
            begin
                cmd.kind = K_OP;
                cmd.op   = OP_MUL;
            end
            CH_SLASH:
            begin
                cmd.kind = K_OP;
                cmd.op   = OP_DIV;
            end
            CH_SPACE, CH_CR:   cmd.kind = K_END;
            CH_LF:             cmd.kind = K_LINE;
            CH_POINT, CH_COMMA: cmd.kind = K_POINT;
            default:
            begin
                if (ch >= CH_ZERO && ch <= CH_NINE)
                begin
                    cmd.kind = K_DIGIT;
                end
            end
        endcase
    end
endmodule

// ===== rtl/core/rsc_back.sv =====
// Execution side: token build, stack and arithmetic, result register.
module rsc_back #(
    parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF,
    parameter int TOKEN_CHARS = rsc_pkg::TOKEN_CHARS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rsc_pkg::cmd_t         cmd,
    input  logic                  cmd_empty,
    output logic                  cmd_pop,
    output logic [31:0]           top_value,
    output logic                  show,
    output logic [2:0]            status,
    output logic                  empty,
    input  logic                  pop,
    output rsc_pkg::back_status_t mon
);
    import rsc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(TOKEN_CHARS + 1);
    localparam logic [AW-1:0] FULL_COUNT = AW'(STACK_DEPTH - 1);
    localparam logic [LW-1:0] TOKEN_MAX  = LW'(TOKEN_CHARS);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_TDIV  = 10'b00_0000_0010,
        S_TPUSH = 10'b00_0000_0100,
        S_OPRD  = 10'b00_0000_1000,
        S_OPA   = 10'b00_0001_0000,
        S_EXEC  = 10'b00_0010_0000,
        S_MULS  = 10'b00_0100_0000,
        S_ODIV  = 10'b00_1000_0000,
        S_WR    = 10'b01_0000_0000,
        S_FIN   = 10'b10_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      count_reg, count_next;
    logic [31:0]        top_reg, top_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [14:0]        int_reg, int_next;
    logic [16:0]        frac_reg, frac_next;
    logic [2:0]         fd_reg, fd_next;
    logic [1:0]         ps_reg, ps_next;
    logic               halted_reg, halted_next;
    cmd_t               cur_reg, cur_next;
    status_t            st_reg, st_next;
    logic               sh_reg, sh_next;
    logic [31:0]        a_reg, a_next;
    logic [31:0]        b_reg, b_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [31:0]        res_reg, res_next;
    logic [31:0]        tok_reg, tok_next;
    logic               neg_reg, neg_next;
    logic               rv_reg, rv_next;
    logic [31:0]        otop_reg, otop_next;
    logic               oshow_reg, oshow_next;
    status_t            ost_reg, ost_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [31:0]        ram_rdata;
    logic               div_start;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic               div_done;
    logic [DIV_N_W-1:0] div_q;

    logic               pop_ok;
    logic               lone_point;
    logic               need_push;
    logic               count_ge2;
    logic [AW-1:0]      wr_count;
    logic [18:0]        int_calc;
    logic [20:0]        frac_calc;
    logic signed [63:0] a64, b64, addsub_w, q64, div_val;
    logic [32:0]        sat_add, sat_mul, sat_div;
    logic [31:0]        abs_a, abs_b;

    rsc_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (count_reg - AW'(2)),
        .rdata (ram_rdata)
    );

    rsc_div #(
        .NW (DIV_N_W),
        .DW (DIV_D_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign pop_ok     = pop && rv_reg;
    assign lone_point = (len_reg == LW'(1)) && (ps_reg != 2'd0);
    assign need_push  = (len_reg != '0) && !lone_point;
    assign count_ge2  = count_reg > AW'(1);
    // two pops and one push: the stack shrinks by one, but never below one word
    assign wr_count   = count_ge2 ? count_reg - AW'(1) : AW'(1);

    assign int_calc  = ({4'b0, int_reg} << 3) + ({4'b0, int_reg} << 1) + {15'b0, cmd.digit};
    assign frac_calc = ({4'b0, frac_reg} << 3) + ({4'b0, frac_reg} << 1)
                       + {17'b0, cmd.digit};

    assign a64      = {{32{a_reg[31]}}, a_reg};
    assign b64      = {{32{b_reg[31]}}, b_reg};
    assign addsub_w = (cur_reg.op == OP_SUB) ? a64 - b64 : a64 + b64;
    assign sat_add  = sat32(addsub_w);
    assign sat_mul  = sat32(prod_reg >>> 16);
    assign q64      = {16'b0, div_q};
    assign div_val  = neg_reg ? -q64 : q64;
    assign sat_div  = sat32(div_val);
    assign abs_a    = a_reg[31] ? (~a_reg + 32'd1) : a_reg;
    assign abs_b    = b_reg[31] ? (~b_reg + 32'd1) : b_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        top_next     = top_reg;
        len_next     = len_reg;
        int_next     = int_reg;
        frac_next    = frac_reg;
        fd_next      = fd_reg;
        ps_next      = ps_reg;
        halted_next  = halted_reg;
        cur_next     = cur_reg;
        st_next      = st_reg;
        sh_next      = sh_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        prod_next    = prod_reg;
        res_next     = res_reg;
        tok_next     = tok_reg;
        neg_next     = neg_reg;
        rv_next      = rv_reg;
        otop_next    = otop_reg;
        oshow_next   = oshow_reg;
        ost_next     = ost_reg;
        ram_we       = 1'b0;
        ram_waddr    = count_reg;
        ram_wdata    = tok_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        cmd_pop      = 1'b0;

        if (pop_ok)
        begin
            rv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    cur_next   = cmd;
                    st_next    = ST_OK;
                    sh_next    = 1'b0;
                    state_next = S_FIN;
                    if (halted_reg)
                    begin
                        st_next = ST_QUIT;
                    end
                    else
                    begin
                        case (cmd.kind)
                            K_QUIT:
                            begin
                                halted_next = 1'b1;
                                st_next     = ST_QUIT;
                            end
                            K_OTHER: st_next = ST_IGNORED;
                            K_DIGIT, K_POINT:
                            begin
                                if (len_reg >= TOKEN_MAX)
                                begin
                                    st_next = ST_TOKEN_FULL;
                                end
                                else
                                begin
                                    len_next = len_reg + LW'(1);
                                    if (cmd.kind == K_POINT)
                                    begin
                                        if (ps_reg != 2'd2)
                                        begin
                                            ps_next = ps_reg + 2'd1;
                                        end
                                    end
                                    else if (ps_reg == 2'd0)
                                    begin
                                        if (int_calc > {4'b0, INT_LIMIT})
                                        begin
                                            int_next = INT_LIMIT;
                                            st_next  = ST_SATURATED;
                                        end
                                        else
                                        begin
                                            int_next = int_calc[14:0];
                                        end
                                    end
                                    else if (ps_reg == 2'd1 && fd_reg < FRAC_MAX_DIGITS)
                                    begin
                                        frac_next = frac_calc[16:0];
                                        fd_next   = fd_reg + 3'd1;
                                    end
                                end
                            end
                            default:
                            begin
                                // token ends here
                                sh_next   = cmd.kind == K_LINE;
                                len_next  = '0;
                                int_next  = '0;
                                frac_next = '0;
                                fd_next   = '0;
                                ps_next   = '0;
                                tok_next  = {1'b0, int_reg, 16'b0};
                                if (need_push)
                                begin
                                    if (fd_reg == 3'd0)
                                    begin
                                        state_next = S_TPUSH;
                                    end
                                    else
                                    begin
                                        div_start    = 1'b1;
                                        div_dividend = {15'b0, frac_reg, 16'b0};
                                        div_divisor  = {15'b0, pow_ten(fd_reg)};
                                        state_next   = S_TDIV;
                                    end
                                end
                                else if (cmd.kind == K_OP)
                                begin
                                    state_next = S_OPRD;
                                end
                            end
                        endcase
                    end
                end
            end
            S_TDIV:
            begin
                if (div_done)
                begin
                    tok_next   = {tok_reg[31:16], div_q[15:0]};
                    state_next = S_TPUSH;
                end
            end
            S_TPUSH:
            begin
                if (count_reg == FULL_COUNT)
                begin
                    st_next = ST_STACK_FULL;
                end
                else
                begin
                    ram_we     = 1'b1;
                    top_next   = tok_reg;
                    count_next = count_reg + AW'(1);
                end
                state_next = (cur_reg.kind == K_OP) ? S_OPRD : S_FIN;
            end
            S_OPRD:
            begin
                b_next     = (count_reg != '0) ? top_reg : 32'd0;
                state_next = S_OPA;
            end
            S_OPA:
            begin
                a_next     = count_ge2 ? ram_rdata : 32'd0;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_WR;
                case (cur_reg.op)
                    OP_ADD, OP_SUB:
                    begin
                        res_next = sat_add[31:0];
                        if (sat_add[32])
                        begin
                            st_next = ST_SATURATED;
                        end
                    end
                    OP_MUL:
                    begin
                        prod_next  = $signed(a_reg) * $signed(b_reg);
                        state_next = S_MULS;
                    end
                    default:
                    begin
                        if (b_reg == 32'd0)
                        begin
                            st_next = ST_DIV_ZERO;
                            if (a_reg == 32'd0)
                                res_next = 32'd0;
                            else if (a_reg[31])
                                res_next = 32'h8000_0000;
                            else
                                res_next = 32'h7FFF_FFFF;
                        end
                        else
                        begin
                            neg_next     = a_reg[31] ^ b_reg[31];
                            div_start    = 1'b1;
                            div_dividend = {abs_a, 16'b0};
                            div_divisor  = abs_b;
                            state_next   = S_ODIV;
                        end
                    end
                endcase
            end
            S_MULS:
            begin
                res_next = sat_mul[31:0];
                if (sat_mul[32])
                begin
                    st_next = ST_SATURATED;
                end
                state_next = S_WR;
            end
            S_ODIV:
            begin
                if (div_done)
                begin
                    res_next = sat_div[31:0];
                    if (sat_div[32])
                    begin
                        st_next = ST_SATURATED;
                    end
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = wr_count - AW'(1);
                ram_wdata  = res_reg;
                top_next   = res_reg;
                count_next = wr_count;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!rv_reg || pop_ok)
                begin
                    rv_next    = 1'b1;
                    otop_next  = (count_reg != '0) ? top_reg : 32'd0;
                    oshow_next = sh_reg;
                    ost_next   = st_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            top_reg    <= '0;
            len_reg    <= '0;
            int_reg    <= '0;
            frac_reg   <= '0;
            fd_reg     <= '0;
            ps_reg     <= '0;
            halted_reg <= 1'b0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            top_reg    <= top_next;
            len_reg    <= len_next;
            int_reg    <= int_next;
            frac_reg   <= frac_next;
            fd_reg     <= fd_next;
            ps_reg     <= ps_next;
            halted_reg <= halted_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        st_reg    <= st_next;
        sh_reg    <= sh_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
        tok_reg   <= tok_next;
        neg_reg   <= neg_next;
        otop_reg  <= otop_next;
        oshow_reg <= oshow_next;
        ost_reg   <= ost_next;
    end

    assign top_value  = otop_reg;
    assign show       = oshow_reg;
    assign status     = ost_reg;
    assign empty      = !rv_reg;
    assign mon.halted = halted_reg;
    assign mon.idle   = state_reg == S_IDLE;
endmodule

// ===== rtl/core/rpn_stack_calculator.sv =====
// RPN calculator top level: classifier, command queue and execution unit.
//
// Usage: characters enter on a queue-style write port (push/full, ch) and
// one result word per character leaves on a queue-style read port
// (empty/pop, top_value, show, status). top_value is the stack top in signed
// Q16.16 after that character, show marks a line feed, status the outcome.
// A two-entry command queue sits between classifier and execution unit, so
// characters are taken while earlier ones are still being worked on.
// Path, accept to word on the result ports: digits, points, ignored
// characters, quit and a token end with no token go straight to the result
// register; a token end that pushes an integer token writes the stack first;
// an operator reads both operands, executes and writes back, multiply with an
// extra scaling step, after pushing any pending token. A fractional token end
// and a divide each make one pass of the 48-step restoring divider. The
// execution unit takes one command at a time.
// Reset empties the stack, clears the token and the halt flag; the stack RAM
// needs no clearing pass. After 'q' every word reports quit until reset.
// If the receiver stalls, the result register holds its word, the queue
// fills and full rises; nothing is dropped.
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF,
    parameter int TOKEN_CHARS = rsc_pkg::TOKEN_CHARS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         ch,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] top_value,
    output logic               show,
    output logic [2:0]         status
);
    import rsc_pkg::*;

    localparam int LVW = $clog2(CMD_QUEUE_DEPTH + 1);

    cmd_t         f_cmd;
    cmd_t         q_cmd;
    logic         f_wr;
    logic         q_full;
    logic         q_empty;
    logic         q_pop;
    logic [LVW-1:0] q_level;
    back_status_t mon;
    logic [31:0]  top_word;

    rsc_front u_front (
        .push      (push),
        .ch        (ch),
        .fifo_full (q_full),
        .full      (full),
        .wr_en     (f_wr),
        .cmd       (f_cmd)
    );

    rsc_cmd_fifo #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (f_wr),
        .wr_cmd (f_cmd),
        .rd_en  (q_pop),
        .rd_cmd (q_cmd),
        .empty  (q_empty),
        .full   (q_full),
        .level  (q_level)
    );

    rsc_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .TOKEN_CHARS (TOKEN_CHARS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .top_value (top_word),
        .show      (show),
        .status    (status),
        .empty     (empty),
        .pop       (pop),
        .mon       (mon)
    );

    assign top_value = $signed(top_word);

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(mon.halted) |-> mon.halted)
        else $error("halt flag cleared without reset");

    a_show_not_quit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && show) |-> (status != ST_QUIT))
        else $error("line feed word reported quit");

    a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop |-> q_level != '0))
        else $error("command taken from empty queue");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> mon.idle)
        else $error("command taken while execution unit busy");
`endif
endmodule

// ===== bench/rsc_checker.sv =====
// Result checker for the RPN stack calculator: predicts each word and compares.
`timescale 1ns / 1ps
module rsc_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [7:0]         ch,
    input  logic               empty,
    input  logic               pop,
    input  logic signed [31:0] top_value,
    input  logic               show,
    input  logic [2:0]         status,
    output int                 fail_count,
    output int                 pending
);
    import rsc_pkg::*;

    localparam int DEPTH = STACK_DEPTH_DEF;

    typedef struct packed {
        logic [31:0] top;
        logic        show;
        logic [2:0]  st;
    } calc_word_t;

    calc_word_t  expected_words[$];
    logic [31:0] stk[DEPTH];
    int unsigned depth_used;
    int unsigned tok_len;
    int unsigned int_acc;
    int unsigned frac_acc;
    int unsigned frac_dig;
    int unsigned points;
    bit          stopped;

    assign pending = expected_words.size();

    function automatic logic [31:0] pop_stk();
        if (depth_used == 0)
            return 32'd0;
        depth_used--;
        return stk[depth_used];
    endfunction

    function automatic bit push_stk(input logic [31:0] v);
        if (depth_used >= DEPTH - 1)
            return 1'b0;
        stk[depth_used] = v;
        depth_used++;
        return 1'b1;
    endfunction

    function automatic status_t close_token();
        longint unsigned p10, frac;
        logic [31:0]     v;
        status_t         s;
        s = ST_OK;
        if (tok_len > 0 && !(tok_len == 1 && points != 0))
        begin
            case (frac_dig)
                1: p10 = 10;
                2: p10 = 100;
                3: p10 = 1000;
                4: p10 = 10000;
                5: p10 = 100000;
                default: p10 = 1;
            endcase
            frac = (longint'(frac_acc) << 16) / p10;
            v = {int_acc[15:0], 16'd0} + {16'd0, frac[15:0]};
            if (!push_stk(v))
                s = ST_STACK_FULL;
        end
        tok_len = 0;
        int_acc = 0;
        frac_acc = 0;
        frac_dig = 0;
        points = 0;
        return s;
    endfunction

    function automatic status_t apply_op(input logic [7:0] c);
        longint a, b, r, p;
        logic [31:0] res;
        b = longint'($signed(pop_stk()));
        a = longint'($signed(pop_stk()));
        if (c == CH_PLUS)
            r = a + b;
        else if (c == CH_MINUS)
            r = a - b;
        else if (c == CH_STAR)
        begin
            p = a * b;
            r = p >>> 16;
        end
        else
        begin
            if (b == 0)
            begin
                res = a > 0 ? 32'h7FFF_FFFF : (a < 0 ? 32'h8000_0000 : 32'd0);
                void'(push_stk(res));
                return ST_DIV_ZERO;
            end
            r = (a * 65536) / b;
        end
        if (r > 64'sd2147483647)
        begin
            void'(push_stk(32'h7FFF_FFFF));
            return ST_SATURATED;
        end
        if (r < -64'sd2147483648)
        begin
            void'(push_stk(32'h8000_0000));
            return ST_SATURATED;
        end
        void'(push_stk(r[31:0]));
        return ST_OK;
    endfunction

    function automatic status_t take_digit(input logic [7:0] c);
        int unsigned n;
        if (tok_len >= TOKEN_CHARS_DEF)
            return ST_TOKEN_FULL;
        tok_len++;
        if (c == CH_POINT || c == CH_COMMA)
        begin
            if (points < 2)
                points++;
            return ST_OK;
        end
        if (points == 0)
        begin
            n = int_acc * 10 + (c - CH_ZERO);
            if (n > INT_LIMIT)
            begin
                int_acc = INT_LIMIT;
                return ST_SATURATED;
            end
            int_acc = n;
        end
        else if (points == 1 && frac_dig < FRAC_MAX_DIGITS)
        begin
            frac_acc = frac_acc * 10 + (c - CH_ZERO);
            frac_dig++;
        end
        return ST_OK;
    endfunction

    function automatic calc_word_t predict_word(input logic [7:0] c);
        calc_word_t w;
        status_t    s1, s2;
        w.show = 1'b0;
        if (stopped)
            w.st = ST_QUIT;
        else if (c == CH_Q_LO || c == CH_Q_UP)
        begin
            stopped = 1'b1;
            w.st = ST_QUIT;
        end
        else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH)
        begin
            s1 = close_token();
            s2 = apply_op(c);
            w.st = (s2 != ST_OK) ? s2 : s1;
        end
        else if (c == CH_SPACE || c == CH_CR)
            w.st = close_token();
        else if (c == CH_LF)
        begin
            w.st = close_token();
            w.show = 1'b1;
        end
        else if (c == CH_POINT || c == CH_COMMA || (c >= CH_ZERO && c <= CH_NINE))
            w.st = take_digit(c);
        else
            w.st = ST_IGNORED;
        w.top = (depth_used == 0) ? 32'd0 : stk[depth_used - 1];
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        calc_word_t w;
        if (!rst_n)
        begin
            expected_words.delete();
            depth_used = 0;
            tok_len = 0;
            int_acc = 0;
            frac_acc = 0;
            frac_dig = 0;
            points = 0;
            stopped = 1'b0;
            fail_count = 0;
        end
        else
        begin
            if (push && !full)
                expected_words.push_back(predict_word(ch));
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected word top=%h show=%b status=%0d",
                             $time, top_value, show, status);
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (top_value !== w.top || show !== w.show || status !== w.st)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected top=%h show=%b status=%0d, actual top=%h show=%b status=%0d",
                                 $time, w.top, w.show, w.st, top_value, show, status);
                    end
                end
            end
        end
    end

endmodule

// ===== bench/tb_rpn_stack_calculator.sv =====
// Testbench top for the RPN stack calculator: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_rpn_stack_calculator;
    import rsc_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic [7:0]         ch = 8'd0;
    logic               pop = 1'b0;
    logic               full, empty, show;
    logic signed [31:0] top_value;
    logic [2:0]         status;
    int                 fail_count, pending;
    int                 cycles = 0;
    bit                 calm = 1'b0;
    bit                 hold_rx = 1'b0;

    always #5 clk = ~clk;

    rpn_stack_calculator i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .ch(ch),
        .empty(empty), .pop(pop), .top_value(top_value), .show(show),
        .status(status)
    );

    rsc_checker i_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .ch(ch),
        .empty(empty), .pop(pop), .top_value(top_value), .show(show),
        .status(status), .fail_count(fail_count), .pending(pending)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** rpn_stack_calculator: FAILED **");
            $finish;
        end
    end

    // receiver: random idle bursts, one long hold-off early on
    initial
    begin
        int n;
        @(posedge rst_n);
        repeat (30) @(posedge clk);
        hold_rx = 1'b1;
        repeat (400) @(posedge clk);
        hold_rx = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rx || (!calm && $urandom_range(0, 7) == 0))
            begin
                pop <= 1'b0;
                n = $urandom_range(1, 9);
                repeat (n - 1) @(posedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic send_word(input logic [7:0] c);
        int n;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            n = $urandom_range(1, 9);
            repeat (n) @(posedge clk);
        end
        push <= 1'b1;
        ch <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i]);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return CH_ZERO + 8'($urandom_range(0, 9));
        if (r < 52) return $urandom_range(0, 1) ? CH_POINT : CH_COMMA;
        if (r < 70) return CH_SPACE;
        if (r < 74) return $urandom_range(0, 1) ? CH_CR : CH_LF;
        if (r < 92)
            case ($urandom_range(0, 3))
                0: return CH_PLUS;
                1: return CH_MINUS;
                2: return CH_STAR;
                default: return CH_SLASH;
            endcase
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        logic [7:0] c;
        int         sent;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: fractions, long tokens, operators, divide by zero, saturation
        send_text("1.5 2,25+\n");
        send_text("99999 32767.99999999 * 0.5 / 3-\n");
        send_text("5 0/ 0 0/ 0 7-0/ . 1..5 x\r");
        send_text("000000000000000000000000000000000000000000000000001 ");
        send_text("32767 32767*32767*- 255 ");
        send_word(8'hFF);
        send_word(8'h00);
        // stack to capacity and beyond, then operators drain it
        for (int i = 0; i < 260; i++)
            send_text("1 ");
        send_text("7 +\n");
        for (int i = 0; i < 260; i++)
            send_word(CH_PLUS);
        sent = 0;
        while (sent < 720)
        begin
            c = pick_char();
            if (c == CH_Q_LO || c == CH_Q_UP)
                c = CH_SPACE;
            if (sent > 620)
                calm = 1'b1;
            send_word(c);
            sent++;
        end
        send_text("Q1 q+");
        push <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("** rpn_stack_calculator: PASSED **");
        else
            $display("** rpn_stack_calculator: FAILED **");
        $finish;
    end

endmodule
